@@ hdl/nfa_ecs_pkg.sv @@
// shared types and constants for the nfa epsilon closure step block
package nfa_ecs_pkg;

    localparam int SET_BITS = 32;   // width of an active set on the result channel
    localparam int SC_W     = 6;    // width of the state_count register
    localparam int LABEL_W  = 8;
    localparam int STATE_W  = 5;    // width of a state number on the input channel

    localparam logic [LABEL_W-1:0] EPS_LABEL = 8'h65;
    localparam logic [SC_W-1:0]    SC_RESET  = 6'd32;

    // register index decoded from the word address
    localparam logic CFG_STATE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_FEED  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_MOVE_RD,
        S_MOVE_PROC,
        S_EPS_RD,
        S_EPS_PROC,
        S_DONE
    } state_t;

endpackage

@@ hdl/nfa_ecs_ram.sv @@
// generic simple dual-port ram with registered read
module nfa_ecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/nfa_ecs_row_match.sv @@
// compares every label byte of one table row against one label
module nfa_ecs_row_match #(
    parameter int NUM_COLS = 32
) (
    input  logic [NUM_COLS*8-1:0] row,
    input  logic [7:0]            label,
    output logic [NUM_COLS-1:0]   hit
);

    always_comb begin
        for (int j = 0; j < NUM_COLS; j++) begin
            hit[j] = (row[j*8 +: 8] == label);
        end
    end

endmodule

@@ hdl/nfa_epsilon_closure_step.sv @@
// top level: nfa simulation step with epsilon closure over a row-organized label table
//
// input channel s_*: one item per handshake. s_tuser carries the op
// (0 write table entry, 1 start, 2 feed symbol, 3 ignored), s_tdata the
// from/to states, the entry label and the symbol. start and feed items give
// one result item on m_*: the active set after closure, bit i for state i.
// write items and op 3 give none.
// the label table is a ram with one row per source state; all labels of a
// row are compared at once by one shared row unit. each processed row is
// read, then merged; a feed item with symbol zero scans no rows. a table
// write reads the row, then writes the patched row back. s_tready is low
// while an item is in work. after reset the table is cleared one row per
// cycle, MAX_STATES rows (at most 32), before the first item is taken;
// state_count resets to 32 and the active set to empty. a finished result
// waits in the output register; a new item is accepted meanwhile, but the
// next result waits until it is taken.
module nfa_epsilon_closure_step #(
    parameter int MAX_STATES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // from_state[4:0], to_state[9:5], label[17:10], symbol[25:18]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // active_set[31:0]
);

    import nfa_ecs_pkg::*;

    localparam int TBL   = (MAX_STATES < SET_BITS) ? MAX_STATES : SET_BITS;
    localparam int IDX_W = $clog2(TBL);
    localparam int ROW_W = TBL * LABEL_W;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_row_reg, clr_row_next;
    logic [SC_W-1:0]       sc_reg, sc_next;
    logic [TBL-1:0]        cur_set_reg, cur_set_next;
    logic [TBL-1:0]        acc_reg, acc_next;
    logic [TBL-1:0]        pend_reg, pend_next;
    logic [LABEL_W-1:0]    sym_reg, sym_next;
    logic [IDX_W-1:0]      wr_from_reg, wr_from_next;
    logic [IDX_W-1:0]      wr_to_reg, wr_to_next;
    logic [LABEL_W-1:0]    wr_label_reg, wr_label_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SET_BITS-1:0]   m_data_reg, m_data_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [ROW_W-1:0]      ram_wdata, ram_rdata, patched_row;
    logic [LABEL_W-1:0]    cmp_label;
    logic [TBL-1:0]        row_hit, new_bits;

    logic [SC_W-1:0]       n_cnt;
    logic [TBL-1:0]        use_mask;
    logic [IDX_W-1:0]      first_idx;
    logic [TBL-1:0]        first_hot;

    logic [1:0]            in_op;
    logic [STATE_W-1:0]    in_from, in_to;
    logic [LABEL_W-1:0]    in_label, in_symbol;
    logic                  cfg_wr;

    assign in_op     = s_tuser;
    assign in_from   = s_tdata[4:0];
    assign in_to     = s_tdata[9:5];
    assign in_label  = s_tdata[17:10];
    assign in_symbol = s_tdata[25:18];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_STATE_COUNT);
    assign prdata = (paddr[2] == CFG_STATE_COUNT) ? 32'(sc_reg) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // states in use: state_count clamped to 1..TBL
    always_comb begin
        if (sc_reg == '0) begin
            n_cnt = SC_W'(1);
        end else if (sc_reg > SC_W'(TBL)) begin
            n_cnt = SC_W'(TBL);
        end else begin
            n_cnt = sc_reg;
        end
        for (int j = 0; j < TBL; j++) begin
            use_mask[j] = (SC_W'(j) < n_cnt);
        end
    end

    // lowest pending row
    always_comb begin
        first_idx = '0;
        for (int j = TBL - 1; j >= 0; j--) begin
            if (pend_reg[j]) begin
                first_idx = IDX_W'(j);
            end
        end
        for (int j = 0; j < TBL; j++) begin
            first_hot[j] = pend_reg[j] && (IDX_W'(j) == first_idx);
        end
    end

    always_comb begin
        for (int j = 0; j < TBL; j++) begin
            patched_row[j*LABEL_W +: LABEL_W] = (IDX_W'(j) == wr_to_reg) ?
                wr_label_reg : ram_rdata[j*LABEL_W +: LABEL_W];
        end
    end

    assign cmp_label = (state_reg == S_MOVE_PROC) ? sym_reg : EPS_LABEL;
    assign new_bits  = row_hit & use_mask & ~acc_reg;

    nfa_ecs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TBL)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nfa_ecs_row_match #(
        .NUM_COLS (TBL)
    ) u_match (
        .row   (ram_rdata),
        .label (cmp_label),
        .hit   (row_hit)
    );

    always_comb begin
        state_next    = state_reg;
        clr_row_next  = clr_row_reg;
        sc_next       = sc_reg;
        cur_set_next  = cur_set_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        sym_next      = sym_reg;
        wr_from_next  = wr_from_reg;
        wr_to_next    = wr_to_reg;
        wr_label_next = wr_label_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = wr_from_reg;
        ram_wdata     = patched_row;
        ram_raddr     = first_idx;

        if (cfg_wr) begin
            sc_next = pwdata[SC_W-1:0];
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_row_reg;
                ram_wdata    = '0;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == IDX_W'(TBL - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_WRITE: begin
                            wr_from_next  = in_from[IDX_W-1:0];
                            wr_to_next    = in_to[IDX_W-1:0];
                            wr_label_next = in_label;
                            if ({1'b0, in_from} < SC_W'(TBL) && {1'b0, in_to} < SC_W'(TBL)) begin
                                state_next = S_WR_RD;
                            end
                        end
                        OP_START: begin
                            acc_next   = TBL'(1);
                            pend_next  = TBL'(1);
                            state_next = S_EPS_RD;
                        end
                        OP_FEED: begin
                            acc_next  = '0;
                            sym_next  = in_symbol;
                            pend_next = cur_set_reg & use_mask;
                            if (in_symbol == '0 || (cur_set_reg & use_mask) == '0) begin
                                pend_next  = '0;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WR_RD: begin
                ram_raddr  = wr_from_reg;
                state_next = S_WR_WB;
            end
            S_WR_WB: begin
                // write back the row with one label replaced
                ram_we     = 1'b1;
                ram_waddr  = wr_from_reg;
                ram_wdata  = patched_row;
                state_next = S_IDLE;
            end
            S_MOVE_RD: begin
                pend_next  = pend_reg & ~first_hot;
                state_next = S_MOVE_PROC;
            end
            S_MOVE_PROC: begin
                acc_next = acc_reg | (row_hit & use_mask);
                if (pend_reg == '0) begin
                    // moved set complete, its states seed the closure
                    pend_next  = acc_reg | (row_hit & use_mask);
                    state_next = ((acc_reg | (row_hit & use_mask)) != '0) ? S_EPS_RD : S_DONE;
                end else begin
                    state_next = S_MOVE_RD;
                end
            end
            S_EPS_RD: begin
                pend_next  = pend_reg & ~first_hot;
                state_next = S_EPS_PROC;
            end
            S_EPS_PROC: begin
                acc_next   = acc_reg | new_bits;
                pend_next  = pend_reg | new_bits;
                state_next = ((pend_reg | new_bits) != '0) ? S_EPS_RD : S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cur_set_next = acc_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = SET_BITS'(acc_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_row_reg <= '0;
            sc_reg      <= SC_RESET;
            cur_set_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            sc_reg      <= sc_next;
            cur_set_reg <= cur_set_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        pend_reg     <= pend_next;
        sym_reg      <= sym_next;
        wr_from_reg  <= wr_from_next;
        wr_to_reg    <= wr_to_next;
        wr_label_reg <= wr_label_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    // closure worklist only ever holds states already in the closure set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EPS_RD || state_reg == S_EPS_PROC) |-> ((pend_reg & ~acc_reg) == '0))
    else $error("pending closure row outside closure set");

    // a result is loaded only from the done state and carries the closure set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_valid_reg || m_tready))
        |=> (m_tvalid && m_tdata == SET_BITS'($past(acc_reg)) && s_tready))
    else $error("result not loaded from closure set");

    // no item is taken while the table is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_tready && (!ram_we || ram_wdata == '0)))
    else $error("item accepted or nonzero row during table clear");
`endif

endmodule
